>>> sv/iphp_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 header parser package
// Shared constants, record types and the protocol classification function.
// ----------------------------------------------------------------------------
package iphp_pkg;

    localparam int HDR_MIN_BYTES = 20;
    localparam int POS_W         = 6;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_LAST      = '1;
    localparam logic [7:0]       OPT_MIN_LEN   = 8'd2;
    localparam logic [4:0]       OPT_MIN_NUM   = 5'd2;
    localparam logic [3:0]       VERSION_IPV4  = 4'd4;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_IGMP = 8'd2;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    typedef enum logic [2:0] {
        PK_ICMP,
        PK_IGMP,
        PK_TCP,
        PK_UDP,
        PK_OTHER
    } t_proto_kind;

    typedef logic [HDR_MIN_BYTES-1:0][7:0] t_hdr_bytes;

    typedef struct packed {
        t_hdr_bytes         hdr;
        logic [POS_W-1:0]   opt_count;
    } t_hdr_rec;

    typedef struct packed {
        logic     valid;
        t_hdr_rec rec;
    } t_push;

    typedef struct packed {
        logic [3:0]  version;
        logic [5:0]  header_bytes;
        logic [7:0]  service_type;
        logic [15:0] datagram_length;
        logic [15:0] packet_ident;
        logic [2:0]  frag_flags;
        logic [12:0] fragment_offset;
        logic [7:0]  time_to_live;
        logic [2:0]  protocol_kind;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [5:0]  option_count;
    } t_result;

    function automatic t_proto_kind proto_class(input logic [7:0] p);
        t_proto_kind k;
        unique case (p)
            PROTO_ICMP: k = PK_ICMP;
            PROTO_IGMP: k = PK_IGMP;
            PROTO_TCP:  k = PK_TCP;
            PROTO_UDP:  k = PK_UDP;
            default:    k = PK_OTHER;
        endcase
        return k;
    endfunction

endpackage

>>> sv/iphp_front.sv
// ----------------------------------------------------------------------------
// IPv4 header parser front end
// Accepts header bytes, stores the fixed header and walks the options.
// ----------------------------------------------------------------------------
module iphp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_start_of_packet,
    input  logic                 i_space,
    output logic                 o_ready,
    output iphp_pkg::t_push      o_push
);

    localparam logic [iphp_pkg::POS_W-1:0] HDR_MIN =
        iphp_pkg::POS_W'(iphp_pkg::HDR_MIN_BYTES);

    logic [iphp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [iphp_pkg::POS_W-1:0] r_next_opt, n_next_opt;
    logic [iphp_pkg::POS_W-1:0] r_opt_start, n_opt_start;
    logic                       r_await_len, n_await_len;
    logic                       r_opt_stop, n_opt_stop;
    logic [iphp_pkg::POS_W-1:0] r_opt_cnt, n_opt_cnt;
    logic                       r_done, n_done;
    iphp_pkg::t_hdr_bytes       r_hdr, n_hdr;
    logic                       accept;
    logic                       emit;

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;

    always_comb begin
        logic [iphp_pkg::POS_W-1:0] pos;
        logic [iphp_pkg::POS_W-1:0] end_len;
        logic [iphp_pkg::POS_W+2:0] sum;
        n_pos       = r_pos;
        n_next_opt  = r_next_opt;
        n_opt_start = r_opt_start;
        n_await_len = r_await_len;
        n_opt_stop  = r_opt_stop;
        n_opt_cnt   = r_opt_cnt;
        n_done      = r_done;
        n_hdr       = r_hdr;
        emit        = 1'b0;
        pos         = '0;
        end_len     = '0;
        sum         = '0;
        if (accept && (i_start_of_packet || !r_done)) begin
            if (i_start_of_packet) begin
                n_pos       = '0;
                n_next_opt  = HDR_MIN;
                n_opt_start = '0;
                n_await_len = 1'b0;
                n_opt_stop  = 1'b0;
                n_opt_cnt   = '0;
                n_done      = 1'b0;
            end
            pos = n_pos;
            if (pos < HDR_MIN) begin
                n_hdr[pos[4:0]] = i_data_byte;
            end else if (!n_opt_stop) begin
                if (n_await_len) begin
                    n_await_len = 1'b0;
                    if (i_data_byte < iphp_pkg::OPT_MIN_LEN) begin
                        n_opt_stop = 1'b1;
                    end else begin
                        sum = {3'b000, n_opt_start} + {1'b0, i_data_byte};
                        n_next_opt = (sum > {3'b000, iphp_pkg::POS_LAST}) ?
                                     iphp_pkg::POS_LAST : sum[iphp_pkg::POS_W-1:0];
                    end
                end else if (pos == n_next_opt) begin
                    if (i_data_byte == 8'd0) begin
                        n_opt_stop = 1'b1;
                    end else begin
                        if (n_opt_cnt != iphp_pkg::POS_LAST) begin
                            n_opt_cnt = n_opt_cnt + 1'b1;
                        end
                        if (i_data_byte[4:0] < iphp_pkg::OPT_MIN_NUM) begin
                            n_next_opt = pos + 1'b1;
                        end else begin
                            n_await_len = 1'b1;
                            n_opt_start = pos;
                        end
                    end
                end
            end
            end_len = {n_hdr[0][3:0], 2'b00};
            if (end_len < HDR_MIN) begin
                end_len = HDR_MIN;
            end
            if (({1'b0, pos} + 1'b1) < {1'b0, end_len}) begin
                n_pos = pos + 1'b1;
            end else begin
                n_done = 1'b1;
                emit   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_next_opt  <= HDR_MIN;
            r_opt_start <= '0;
            r_await_len <= 1'b0;
            r_opt_stop  <= 1'b0;
            r_opt_cnt   <= '0;
            r_done      <= 1'b1;
        end else begin
            r_pos       <= n_pos;
            r_next_opt  <= n_next_opt;
            r_opt_start <= n_opt_start;
            r_await_len <= n_await_len;
            r_opt_stop  <= n_opt_stop;
            r_opt_cnt   <= n_opt_cnt;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    assign o_push.valid         = emit;
    assign o_push.rec.hdr       = n_hdr;
    assign o_push.rec.opt_count = n_opt_cnt;

endmodule

>>> sv/iphp_queue.sv
// ----------------------------------------------------------------------------
// IPv4 header parser queue
// Short queue of finished header records between the front and back ends.
// ----------------------------------------------------------------------------
module iphp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iphp_pkg::t_push     i_push,
    input  logic                i_pop,
    output logic                o_space,
    output logic                o_valid,
    output iphp_pkg::t_hdr_rec  o_rec
);

    localparam logic [iphp_pkg::QCNT_W-1:0] DEPTH =
        iphp_pkg::QCNT_W'(iphp_pkg::QUEUE_DEPTH);
    localparam logic [iphp_pkg::QPTR_W-1:0] PTR_LAST =
        iphp_pkg::QPTR_W'(iphp_pkg::QUEUE_DEPTH - 1);

    iphp_pkg::t_hdr_rec          r_mem [iphp_pkg::QUEUE_DEPTH];
    logic [iphp_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [iphp_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [iphp_pkg::QCNT_W-1:0] r_count;
    logic                        push;
    logic                        pop;

    assign o_space = (r_count < DEPTH);
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign push    = i_push.valid;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.rec;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_count < DEPTH))
        else $error("record pushed into a full queue");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not rise on push");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!push && pop) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not fall on pop");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && pop) |=> $stable(r_count))
        else $error("queue count changed on push with pop");

endmodule

>>> sv/iphp_back.sv
// ----------------------------------------------------------------------------
// IPv4 header parser back end
// Unpacks queued header records into the registered result port.
// ----------------------------------------------------------------------------
module iphp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  iphp_pkg::t_hdr_rec  i_q_rec,
    output logic                o_pop,
    input  logic                i_ready,
    output logic                o_valid,
    output iphp_pkg::t_result   o_result
);

    logic               r_valid;
    iphp_pkg::t_result  r_result;
    iphp_pkg::t_result  n_result;
    logic               take;

    assign take  = i_q_valid && (!r_valid || i_ready);
    assign o_pop = take;

    always_comb begin
        iphp_pkg::t_hdr_bytes h;
        logic                 is_v4;
        h     = i_q_rec.hdr;
        is_v4 = (h[0][7:4] == iphp_pkg::VERSION_IPV4);
        n_result.version             = h[0][7:4];
        n_result.header_bytes        = {h[0][3:0], 2'b00};
        n_result.service_type        = h[1];
        n_result.datagram_length     = {h[2], h[3]};
        n_result.packet_ident        = {h[4], h[5]};
        n_result.frag_flags          = h[6][7:5];
        n_result.fragment_offset     = {h[6][4:0], h[7]};
        n_result.time_to_live        = h[8];
        n_result.protocol_kind       = iphp_pkg::proto_class(h[9]);
        n_result.source_address      = is_v4 ? {h[12], h[13], h[14], h[15]} : '0;
        n_result.destination_address = is_v4 ? {h[16], h[17], h[18], h[19]} : '0;
        n_result.option_count        = i_q_rec.opt_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> sv/ipv4_header_parser.sv
// ----------------------------------------------------------------------------
// IPv4 header parser
// Streams header bytes in, walks the options and reports the unpacked header.
// ----------------------------------------------------------------------------
// Throughput is one header byte per cycle; input stalls only when the
// two-entry record queue is full.
// After the last header byte is accepted, the record passes through the
// record queue and then the output register before the result is valid.
// Reset clears all control state; the parser then ignores bytes until a
// byte marked as start of packet arrives.
module ipv4_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_packet,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_version,
    output logic [5:0]  o_header_bytes,
    output logic [7:0]  o_service_type,
    output logic [15:0] o_datagram_length,
    output logic [15:0] o_packet_ident,
    output logic [2:0]  o_frag_flags,
    output logic [12:0] o_fragment_offset,
    output logic [7:0]  o_time_to_live,
    output logic [2:0]  o_protocol_kind,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address,
    output logic [5:0]  o_option_count
);

    iphp_pkg::t_push     push;
    logic                q_space;
    logic                q_valid;
    iphp_pkg::t_hdr_rec  q_rec;
    logic                q_pop;
    iphp_pkg::t_result   result;

    iphp_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .i_data_byte       (i_data_byte),
        .i_start_of_packet (i_start_of_packet),
        .i_space           (q_space),
        .o_ready           (o_ready),
        .o_push            (push)
    );

    iphp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_space (q_space),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    iphp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_rec   (q_rec),
        .o_pop     (q_pop),
        .i_ready   (i_ready),
        .o_valid   (o_valid),
        .o_result  (result)
    );

    assign o_version             = result.version;
    assign o_header_bytes        = result.header_bytes;
    assign o_service_type        = result.service_type;
    assign o_datagram_length     = result.datagram_length;
    assign o_packet_ident        = result.packet_ident;
    assign o_frag_flags          = result.frag_flags;
    assign o_fragment_offset     = result.fragment_offset;
    assign o_time_to_live        = result.time_to_live;
    assign o_protocol_kind       = result.protocol_kind;
    assign o_source_address      = result.source_address;
    assign o_destination_address = result.destination_address;
    assign o_option_count        = result.option_count;

endmodule
